FILE: hw/rtl/svalloc_pkg.sv
// Shared types and constants for the sound voice allocator.
`timescale 1ns / 1ps
package svalloc_pkg;
	localparam int NUM_VOICES_DEF = 32;
	localparam int RING_DEPTH_DEF = 8;
	localparam int NUM_SOUNDS_DEF = 128;

	localparam logic [5:0] SKIP_VOICE_A = 6'd16;
	localparam logic [5:0] SKIP_VOICE_B = 6'd17;

	typedef enum logic [2:0] {
		OP_PLAY      = 3'd0,
		OP_STOP_ONE  = 3'd1,
		OP_STOP_OWN  = 3'd2,
		OP_STOP_LOOP = 3'd3,
		OP_ADJUST    = 3'd4,
		OP_FRAME     = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ACT_KEY_ON    = 3'd0,
		ACT_KEY_OFF   = 3'd1,
		ACT_SET_LEVEL = 3'd2,
		ACT_DONE      = 3'd3,
		ACT_REJECT    = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		RET_IDLE,
		RET_PRE,
		RET_POST
	} ret_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LSCAN,
		ST_FRD,
		ST_FCHK,
		ST_TAKE_CHK,
		ST_RF_CHK,
		ST_RF_SCAN,
		ST_TAKE,
		ST_KEYON,
		ST_VSCAN,
		ST_DONE,
		ST_REJECT
	} state_t;
endpackage

FILE: hw/rtl/sound_voice_allocator.sv
// Sound voice allocator: voice table, silent-voice ring and request sequencer.
`timescale 1ns / 1ps
// One request at a time. A scan op (stop one/owner/looped, adjust, looped play check)
// steps through the voice table one voice per cycle, unless a match waits on an output
// stall. A play adds a ring refill: a check step per refilled slot, then scan steps,
// at most NUM_VOICES scan steps per slot. Next frame goes straight to its done beat.
// After reset the ring is filled silently before the first request is taken. Each
// request ends with one done or rejected beat with tlast set.
module sound_voice_allocator import svalloc_pkg::*; #(
	parameter int NUM_VOICES = NUM_VOICES_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int NUM_SOUNDS = NUM_SOUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // owner, sound_number, sound_looped, volume, pan
	input  logic [2:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // voice, sound_id, level, pan_out
	output logic [2:0]  m_axis_tuser,  // action
	output logic        m_axis_tlast
);
	localparam int VW = $clog2(NUM_VOICES);
	localparam int RW = $clog2(RING_DEPTH);
	localparam int SW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	logic              stereo_q;
	logic [2:0]        op_q;
	logic [15:0]       owner_q;
	logic [6:0]        snd_q;
	logic              looped_q;
	logic [7:0]        vol_q;
	logic [4:0]        pan_q;

	logic [15:0]       owner_mem_q [NUM_VOICES];
	logic [6:0]        sound_tab_q [NUM_VOICES];
	logic [NUM_VOICES-1:0] busy_q, loops_q;
	logic [VW-1:0]     ring_q [RING_DEPTH];
	logic [RW-1:0]     head_q, tail_q;
	logic [VW-1:0]     scan_q, tries_q, vidx_q, take_v_q;
	logic [7:0]        frame_q;
	logic [7:0]        slf_mem [NUM_SOUNDS];
	logic [7:0]        slf_rd_q;
	logic [NUM_SOUNDS-1:0] slf_vld_q;

	logic              m_valid_q, m_last_q;
	logic [2:0]        m_act_q;
	logic [24:0]       m_data_q;

	logic              emit, emit_ok;
	act_t              e_act;
	logic [VW-1:0]     e_voice;
	logic              e_full;
	logic              scan_step, scan_start, ring_push, take, vidx_clr, vidx_inc;
	logic              busy_clr, keyon_wr, frame_inc, ret_we;

	logic [VW-1:0]     pn;
	logic              elig, m_own, m_snd, v_match;
	logic [RW-1:0]     head_nx, tail_nx;
	logic [SW-1:0]     sidx;

	function automatic logic [RW-1:0] rnext(input logic [RW-1:0] i);
		return (i == RW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign pn      = (scan_q == VW'(NUM_VOICES - 1)) ? '0 : scan_q + 1'b1;
	assign elig    = (6'(pn) != SKIP_VOICE_A) && (6'(pn) != SKIP_VOICE_B)
	                 && !(busy_q[pn] && loops_q[pn]);
	assign head_nx = rnext(head_q);
	assign tail_nx = rnext(tail_q);
	assign sidx    = SW'(snd_q);
	assign m_own   = busy_q[vidx_q] && (owner_mem_q[vidx_q] == owner_q);
	assign m_snd   = m_own && (sound_tab_q[vidx_q] == snd_q);
	assign emit_ok = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		case (op_q)
			OP_STOP_ONE:  v_match = m_snd;
			OP_STOP_LOOP: v_match = busy_q[vidx_q] && loops_q[vidx_q];
			default:      v_match = m_own;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		ret_we = 1'b0;
		emit = 1'b0;
		e_act = ACT_DONE;
		e_voice = '0;
		e_full = 1'b0;
		scan_step = 1'b0;
		scan_start = 1'b0;
		ring_push = 1'b0;
		take = 1'b0;
		vidx_clr = 1'b0;
		vidx_inc = 1'b0;
		busy_clr = 1'b0;
		keyon_wr = 1'b0;
		frame_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				vidx_clr = 1'b1;
				if (s_axis_tvalid) begin
					case (s_axis_tuser)
						OP_PLAY: begin
							if ({2'b0, s_axis_tdata[22:16]} >= 9'(NUM_SOUNDS))
								state_d = ST_REJECT;
							else if (s_axis_tdata[23])
								state_d = ST_LSCAN;
							else
								state_d = ST_FRD;
						end
						OP_STOP_ONE, OP_STOP_OWN, OP_STOP_LOOP, OP_ADJUST: state_d = ST_VSCAN;
						OP_FRAME: state_d = ST_DONE;
						default: state_d = ST_REJECT;
					endcase
					frame_inc = (s_axis_tuser == OP_FRAME);
				end
			end
			ST_LSCAN: begin
				vidx_inc = 1'b1;
				if (m_snd)
					state_d = ST_REJECT;
				else if (vidx_q == VW'(NUM_VOICES - 1))
					state_d = ST_TAKE_CHK;
			end
			ST_FRD: state_d = ST_FCHK;
			ST_FCHK: begin
				if (slf_vld_q[sidx] && slf_rd_q == frame_q)
					state_d = ST_REJECT;
				else
					state_d = ST_TAKE_CHK;
			end
			ST_TAKE_CHK: begin
				if (head_q == tail_q) begin
					ret_d = RET_PRE;
					ret_we = 1'b1;
					state_d = ST_RF_CHK;
				end else begin
					state_d = ST_TAKE;
				end
			end
			ST_RF_CHK: begin
				if (head_nx == tail_q) begin
					case (ret_q)
						RET_PRE:  state_d = (head_q == tail_q) ? ST_REJECT : ST_TAKE;
						RET_POST: state_d = ST_KEYON;
						default:  state_d = ST_IDLE;
					endcase
				end else begin
					scan_start = 1'b1;
					state_d = ST_RF_SCAN;
				end
			end
			ST_RF_SCAN: begin
				if (elig) begin
					if (ret_q == RET_IDLE || emit_ok) begin
						scan_step = 1'b1;
						ring_push = 1'b1;
						emit = (ret_q != RET_IDLE);
						e_act = ACT_KEY_OFF;
						e_voice = pn;
						state_d = ST_RF_CHK;
					end
				end else begin
					scan_step = 1'b1;
					if (tries_q == VW'(NUM_VOICES - 1)) begin
						case (ret_q)
							RET_PRE:  state_d = (head_q == tail_q) ? ST_REJECT : ST_TAKE;
							RET_POST: state_d = ST_KEYON;
							default:  state_d = ST_IDLE;
						endcase
					end
				end
			end
			ST_TAKE: begin
				take = 1'b1;
				ret_d = RET_POST;
				ret_we = 1'b1;
				state_d = ST_RF_CHK;
			end
			ST_KEYON: begin
				if (emit_ok) begin
					emit = 1'b1;
					e_act = ACT_KEY_ON;
					e_voice = take_v_q;
					e_full = 1'b1;
					keyon_wr = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_VSCAN: begin
				if (v_match && !emit_ok) begin
					state_d = ST_VSCAN;
				end else begin
					vidx_inc = 1'b1;
					if (v_match) begin
						emit = 1'b1;
						e_voice = vidx_q;
						e_act = (op_q == OP_ADJUST) ? ACT_SET_LEVEL : ACT_KEY_OFF;
						e_full = (op_q == OP_ADJUST);
						busy_clr = (op_q != OP_ADJUST);
					end
					if ((v_match && op_q == OP_STOP_ONE) || vidx_q == VW'(NUM_VOICES - 1))
						state_d = ST_DONE;
				end
			end
			ST_DONE, ST_REJECT: begin
				if (emit_ok) begin
					emit = 1'b1;
					e_act = (state_q == ST_DONE) ? ACT_DONE : ACT_REJECT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RF_CHK;
			ret_q <= RET_IDLE;
		end else begin
			state_q <= state_d;
			if (ret_we)
				ret_q <= ret_d;
			else if (state_q == ST_IDLE)
				ret_q <= RET_PRE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b1;
			busy_q <= '0;
			loops_q <= '0;
			for (int i = 0; i < NUM_VOICES; i++)
				sound_tab_q[i] <= '0;
			head_q <= '0;
			tail_q <= '0;
			scan_q <= '0;
			tries_q <= '0;
			vidx_q <= '0;
			frame_q <= 8'd1;
			slf_vld_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				stereo_q <= cfg_wdata;
			if (vidx_clr)
				vidx_q <= '0;
			else if (vidx_inc)
				vidx_q <= vidx_q + 1'b1;
			if (scan_start)
				tries_q <= '0;
			else if (scan_step)
				tries_q <= tries_q + 1'b1;
			if (scan_step)
				scan_q <= pn;
			if (ring_push) begin
				head_q <= head_nx;
				busy_q[pn] <= 1'b0;
			end
			if (busy_clr)
				busy_q[vidx_q] <= 1'b0;
			if (take) begin
				tail_q <= tail_nx;
				if (!looped_q)
					slf_vld_q[sidx] <= 1'b1;
			end
			if (keyon_wr) begin
				busy_q[take_v_q] <= 1'b1;
				loops_q[take_v_q] <= looped_q;
				sound_tab_q[take_v_q] <= snd_q;
			end
			if (frame_inc) begin
				if (frame_q == 8'hff) begin
					frame_q <= 8'd1;
					slf_vld_q <= '0;
				end else begin
					frame_q <= frame_q + 8'd1;
				end
			end
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q <= s_axis_tuser;
			owner_q <= s_axis_tdata[15:0];
			snd_q <= s_axis_tdata[22:16];
			looped_q <= s_axis_tdata[23];
			vol_q <= s_axis_tdata[31:24];
			pan_q <= stereo_q ? s_axis_tdata[36:32] : 5'd0;
		end
		if (ring_push)
			ring_q[head_q] <= pn;
		if (take) begin
			take_v_q <= ring_q[tail_q];
			if (!looped_q)
				slf_mem[sidx] <= frame_q;
		end
		slf_rd_q <= slf_mem[sidx];
		if (keyon_wr)
			owner_mem_q[take_v_q] <= owner_q;
		if (emit) begin
			m_act_q <= e_act;
			m_last_q <= (e_act == ACT_DONE) || (e_act == ACT_REJECT);
			m_data_q <= {e_full ? pan_q : 5'd0,
			             e_full ? vol_q : 8'd0,
			             (e_act == ACT_KEY_ON) ? snd_q : 7'd0,
			             5'(e_voice)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_data_q};
	assign m_axis_tuser  = m_act_q;
	assign m_axis_tlast  = m_last_q;

	a_frame_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q != 8'd0) else $error("frame counter reached zero");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready held across an accepted request");
	a_ring_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		ring_push |-> (6'(pn) != SKIP_VOICE_A) && (6'(pn) != SKIP_VOICE_B))
		else $error("reserved voice pushed into silent ring");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
		(m_axis_tuser == ACT_DONE) || (m_axis_tuser == ACT_REJECT))
		else $error("last beat is not done or rejected");
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the sound voice allocator: directed table, then random requests.
`timescale 1ns / 1ps
module tb_top;
	import svalloc_pkg::*;

	localparam int LIMIT = 1000000;

	typedef struct {
		logic [4:0] voice;
		act_t       action;
		logic [6:0] sound_id;
		logic [7:0] level;
		logic [4:0] pan_out;
		logic       last;
	} beat_t;

	typedef struct {
		logic [2:0]  op;
		logic [15:0] owner;
		logic [6:0]  snd;
		logic        looped;
		logic [7:0]  vol;
		logic [4:0]  pan;
		logic        typed;
		act_t        act;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // owner, sound_number, sound_looped, volume, pan
	logic [2:0]  s_axis_tuser = '0;  // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;       // voice, sound_id, level, pan_out
	logic [2:0]  m_axis_tuser;       // action
	logic        m_axis_tlast;

	sound_voice_allocator u_dut (.*);

	always #1 clk = ~clk;

	// allocator mirror
	logic        stereo;
	logic [15:0] own_tab [32];
	logic        busy_tab [32];
	logic [6:0]  snd_tab [32];
	logic        loop_tab [32];
	logic [4:0]  ring [8];
	logic [2:0]  head, tail;
	logic [4:0]  scan;
	logic [7:0]  frame;
	logic [7:0]  last_frame [128];
	logic        emit_on;

	beat_t expected_beats[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_long = 0;

	function automatic void emit(logic [4:0] v, act_t a, logic [6:0] s, logic [7:0] l,
		logic [4:0] p, logic lst);
		beat_t b;
		if (!emit_on) return;
		b.voice = v; b.action = a; b.sound_id = s; b.level = l; b.pan_out = p; b.last = lst;
		expected_beats.push_back(b);
	endfunction

	function automatic void refill_ring();
		logic [4:0] p;
		bit found;
		while (head + 3'd1 != tail) begin
			p = scan;
			found = 0;
			for (int t = 0; t < 32; t++) begin
				p = p + 5'd1;
				if (p == 5'd16 || p == 5'd17) continue;
				if (busy_tab[p] && loop_tab[p]) continue;
				found = 1;
				break;
			end
			scan = p;
			if (!found) return;
			ring[head] = p;
			head = head + 3'd1;
			busy_tab[p] = 0;
			emit(p, ACT_KEY_OFF, 0, 0, 0, 0);
		end
	endfunction

	function automatic void mirror_reset();
		for (int i = 0; i < 32; i++) begin
			busy_tab[i] = 0; snd_tab[i] = 0; loop_tab[i] = 0; own_tab[i] = 0;
		end
		for (int i = 0; i < 128; i++) last_frame[i] = 0;
		head = 0; tail = 0; scan = 0; frame = 1; stereo = 1;
		emit_on = 0;
		refill_ring();
		emit_on = 1;
	endfunction

	function automatic void predict_request(row_t r);
		logic [4:0] pn;
		logic [4:0] v;
		pn = stereo ? r.pan : 5'd0;
		case (r.op)
			OP_PLAY: begin
				if (r.looped) begin
					for (int i = 0; i < 32; i++)
						if (busy_tab[i] && own_tab[i] == r.owner && snd_tab[i] == r.snd) begin
							emit(0, ACT_REJECT, 0, 0, 0, 1);
							return;
						end
				end else if (last_frame[r.snd] == frame) begin
					emit(0, ACT_REJECT, 0, 0, 0, 1);
					return;
				end
				if (head == tail) refill_ring();
				if (head == tail) begin
					emit(0, ACT_REJECT, 0, 0, 0, 1);
					return;
				end
				if (!r.looped) last_frame[r.snd] = frame;
				v = ring[tail];
				tail = tail + 3'd1;
				refill_ring();
				busy_tab[v] = 1; own_tab[v] = r.owner; snd_tab[v] = r.snd; loop_tab[v] = r.looped;
				emit(v, ACT_KEY_ON, r.snd, r.vol, pn, 0);
			end
			OP_STOP_ONE: begin
				for (int i = 0; i < 32; i++)
					if (busy_tab[i] && own_tab[i] == r.owner && snd_tab[i] == r.snd) begin
						busy_tab[i] = 0;
						emit(5'(i), ACT_KEY_OFF, 0, 0, 0, 0);
						break;
					end
			end
			OP_STOP_OWN: begin
				for (int i = 0; i < 32; i++)
					if (busy_tab[i] && own_tab[i] == r.owner) begin
						busy_tab[i] = 0;
						emit(5'(i), ACT_KEY_OFF, 0, 0, 0, 0);
					end
			end
			OP_STOP_LOOP: begin
				for (int i = 0; i < 32; i++)
					if (busy_tab[i] && loop_tab[i]) begin
						busy_tab[i] = 0;
						emit(5'(i), ACT_KEY_OFF, 0, 0, 0, 0);
					end
			end
			OP_ADJUST: begin
				for (int i = 0; i < 32; i++)
					if (busy_tab[i] && own_tab[i] == r.owner)
						emit(5'(i), ACT_SET_LEVEL, 0, r.vol, pn, 0);
			end
			OP_FRAME: begin
				frame = frame + 8'd1;
				if (frame == 0) begin
					frame = 1;
					for (int i = 0; i < 128; i++) last_frame[i] = 0;
				end
			end
			default: begin
				emit(0, ACT_REJECT, 0, 0, 0, 1);
				return;
			end
		endcase
		emit(0, ACT_DONE, 0, 0, 0, 1);
	endfunction

	task automatic send_request(row_t r);
		beat_t b;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= r.op;
		s_axis_tdata <= {3'b0, r.pan, r.vol, r.looped, r.snd, r.owner};
		do @(posedge clk); while (!s_axis_tready);
		emit_on = !r.typed;
		predict_request(r);
		emit_on = 1;
		if (r.typed) begin
			b.voice = 0; b.action = r.act; b.sound_id = 0; b.level = 0; b.pan_out = 0; b.last = 1;
			expected_beats.push_back(b);
		end
	endtask

	task automatic write_stereo(logic val);
		s_axis_tvalid <= 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= val;
		@(posedge clk);
		stereo = val;
		cfg_we <= 0;
	endtask

	function automatic row_t random_request();
		row_t r;
		int k;
		logic [15:0] owners [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hffff};
		logic [6:0]  sounds [4] = '{7'd0, 7'd1, 7'd64, 7'd127};
		k = $urandom_range(0, 99);
		r.op = k < 45 ? OP_PLAY : k < 55 ? OP_STOP_ONE : k < 65 ? OP_STOP_OWN :
			k < 70 ? OP_STOP_LOOP : k < 85 ? OP_ADJUST : k < 96 ? OP_FRAME :
			3'($urandom_range(6, 7));
		r.owner = $urandom_range(0, 3) != 0 ? owners[$urandom_range(0, 3)] : 16'($urandom);
		r.snd = $urandom_range(0, 9) < 7 ? sounds[$urandom_range(0, 3)] : 7'($urandom);
		r.looped = 1'($urandom_range(0, 1));
		r.vol = 8'($urandom);
		r.pan = 5'($urandom);
		r.typed = 0;
		r.act = ACT_DONE;
		return r;
	endfunction

	row_t directed [19] = '{
		'{3'd6, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b1, ACT_REJECT},
		'{3'd7, 16'hffff, 7'd127, 1'b1, 8'hff, 5'h1f, 1'b1, ACT_REJECT},
		'{OP_FRAME, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b1, ACT_DONE},
		'{OP_STOP_ONE, 16'h1234, 7'd3, 1'b0, 8'h00, 5'h00, 1'b1, ACT_DONE},
		'{OP_STOP_OWN, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b1, ACT_DONE},
		'{OP_STOP_LOOP, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b1, ACT_DONE},
		'{OP_ADJUST, 16'hffff, 7'd0, 1'b0, 8'hff, 5'h1f, 1'b1, ACT_DONE},
		'{OP_PLAY, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b0, ACT_DONE},
		'{OP_PLAY, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b1, ACT_REJECT},
		'{OP_PLAY, 16'hffff, 7'd127, 1'b1, 8'hff, 5'h1f, 1'b0, ACT_DONE},
		'{OP_PLAY, 16'hffff, 7'd127, 1'b1, 8'h10, 5'h01, 1'b1, ACT_REJECT},
		'{OP_ADJUST, 16'hffff, 7'd0, 1'b0, 8'h80, 5'h10, 1'b0, ACT_DONE},
		'{OP_STOP_ONE, 16'hffff, 7'd127, 1'b0, 8'h00, 5'h00, 1'b0, ACT_DONE},
		'{OP_PLAY, 16'h0001, 7'd5, 1'b1, 8'h40, 5'h0f, 1'b0, ACT_DONE},
		'{OP_STOP_LOOP, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b0, ACT_DONE},
		'{OP_PLAY, 16'h0002, 7'd9, 1'b0, 8'h22, 5'h11, 1'b0, ACT_DONE},
		'{OP_STOP_OWN, 16'h0002, 7'd0, 1'b0, 8'h00, 5'h00, 1'b0, ACT_DONE},
		'{OP_FRAME, 16'h0000, 7'd0, 1'b0, 8'h00, 5'h00, 1'b0, ACT_DONE},
		'{OP_PLAY, 16'h0000, 7'd0, 1'b0, 8'h7f, 5'h0a, 1'b0, ACT_DONE}
	};

	always @(posedge clk) begin
		beat_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (m_axis_tdata[4:0] !== e.voice) begin
					$error("voice: expected %0d, got %0d", e.voice, m_axis_tdata[4:0]); errors++;
				end
				if (m_axis_tuser !== e.action) begin
					$error("action: expected %0d, got %0d", e.action, m_axis_tuser); errors++;
				end
				if (m_axis_tdata[11:5] !== e.sound_id) begin
					$error("sound_id: expected %0d, got %0d", e.sound_id, m_axis_tdata[11:5]);
					errors++;
				end
				if (m_axis_tdata[19:12] !== e.level) begin
					$error("level: expected %0d, got %0d", e.level, m_axis_tdata[19:12]); errors++;
				end
				if (m_axis_tdata[24:20] !== e.pan_out) begin
					$error("pan_out: expected %0d, got %0d", e.pan_out, m_axis_tdata[24:20]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, m_axis_tlast); errors++;
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 0;
				m_axis_tready <= 0;
				repeat (500) @(posedge clk);
				m_axis_tready <= 1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		row_t r;
		mirror_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		write_stereo(1);
		foreach (directed[i]) send_request(directed[i]);
		write_stereo(0);
		repeat (50) send_request(random_request());
		write_stereo(1);
		// long output stall during a run of looped plays
		hold_long = 1;
		repeat (20) begin
			r = random_request();
			r.op = OP_PLAY;
			r.looped = 1;
			r.owner = 16'($urandom);
			send_request(r);
		end
		repeat (30) send_request(random_request());
		quiet = 1;
		repeat (30) send_request(random_request());
		s_axis_tvalid <= 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
